FILE: sv/swmmm_pkg.sv
// ----------------------------------------------------------------------------
// swmmm_pkg
// Shared constants for the sliding-window min / max / mean core: default
// sizing, fixed field widths and the reset window length.
// ----------------------------------------------------------------------------
package swmmm_pkg;

    // default sizing of the sample store
    localparam int SWMMM_MAX_WINDOW  = 64;
    localparam int SWMMM_SAMPLE_BITS = 16;

    // fixed field widths of the ports
    localparam int CFG_W = 7;   // window_size write data
    localparam int CNT_W = 7;   // held_count result field

    // window length after reset
    localparam int WIN_RESET = 10;

endpackage : swmmm_pkg

FILE: sv/sliding_window_min_max_mean_core.sv
// Sequence: an accepted input beat is written to memory, the held entries are
//   read back one per cycle in the scan, the divider works on the magnitude
//   of the sum, and the result is registered once the output is free.
// Throughput: a new sample is taken only in idle, after the result is stored.
// Reset (sync, active low): window length 10, window empty, no result pending;
//   sample memory is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core
// Ring window of signed samples. Each input beat pushes one sample, then the
// held entries are scanned from memory for min, max and sum, and the sum is
// divided by the count (truncated toward zero) to give the mean.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_core #(
    parameter int MAX_WINDOW  = swmmm_pkg::SWMMM_MAX_WINDOW,
    parameter int SAMPLE_BITS = swmmm_pkg::SWMMM_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: window_size
    input  logic                           i_cfg_wr_en,
    input  logic [swmmm_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // sample input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    // result output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [swmmm_pkg::CNT_W-1:0]    o_held_count,
    output logic signed [SAMPLE_BITS-1:0]  o_window_min,
    output logic signed [SAMPLE_BITS-1:0]  o_window_max,
    output logic signed [SAMPLE_BITS-1:0]  o_window_mean
);

    import swmmm_pkg::*;

    localparam int AW      = $clog2(MAX_WINDOW);          // memory address
    localparam int CW      = $clog2(MAX_WINDOW + 1);      // counts 0..MAX_WINDOW
    localparam int XW      = (CW > CFG_W) ? CW : CFG_W;   // clamp compare width
    localparam int SW      = SAMPLE_BITS + CW;            // signed sum width
    localparam int DCW     = $clog2(SW + 1);              // divider step count
    localparam int WIN_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // sample memory (no reset)
    logic [SAMPLE_BITS-1:0] mem_store [MAX_WINDOW];

    // control registers
    logic [1:0]     r_state, n_state;
    logic [CW-1:0]  r_win,   n_win;
    logic [CW-1:0]  r_fill,  n_fill;
    logic [CW-1:0]  r_ptr,   n_ptr;
    logic [CW-1:0]  r_rd_idx, n_rd_idx;
    logic           r_rd_vld;
    logic           r_first, n_first;
    logic [DCW-1:0] r_div_cnt, n_div_cnt;
    logic           r_out_vld, n_out_vld;

    // datapath registers
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic signed [SW-1:0]          r_sum, n_sum;
    logic [SW-1:0]                 r_quo, n_quo;
    logic [CW-1:0]                 r_rem, n_rem;
    logic                          r_neg, n_neg;
    logic [CNT_W-1:0]              r_out_cnt, n_out_cnt;
    logic signed [SAMPLE_BITS-1:0] r_out_min, n_out_min;
    logic signed [SAMPLE_BITS-1:0] r_out_max, n_out_max;
    logic signed [SAMPLE_BITS-1:0] r_out_mean, n_out_mean;

    // combinational helpers
    logic                 in_acc;
    logic                 out_free;
    logic                 full;
    logic [CW-1:0]        ptr_use;
    logic [CW-1:0]        ptr_inc;
    logic [XW-1:0]        cfg_ext;
    logic [CW-1:0]        win_cfg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic signed [SW-1:0] rdata_ext;
    logic [SW-1:0]        sum_mag;
    logic [CW:0]          trial;
    logic [CW:0]          fill_ext;
    logic [CW:0]          diff;
    logic                 ge;
    logic [SW-1:0]        quo_signed;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_vld || i_out_ready;

    // window length write, clamped to 1..MAX_WINDOW
    assign cfg_ext = XW'(i_cfg_wr_data);
    assign win_cfg = (cfg_ext == '0)             ? CW'(1) :
                     (cfg_ext > XW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) :
                                                   CW'(cfg_ext);

    // push position: append while filling, else overwrite oldest
    assign full    = (r_fill >= r_win);
    assign ptr_use = (r_ptr >= r_win) ? '0 : r_ptr;
    assign ptr_inc = ptr_use + CW'(1);
    assign wr_en   = in_acc;
    assign wr_addr = full ? ptr_use[AW-1:0] : r_fill[AW-1:0];

    // scan reads; writes happen only in idle, reads only in scan
    assign rd_en   = (r_state == S_SCAN) && (r_rd_idx != r_fill);
    assign rd_addr = r_rd_idx[AW-1:0];

    assign rdata_ext = {{(SW-SAMPLE_BITS){r_rdata[SAMPLE_BITS-1]}}, r_rdata};
    assign sum_mag   = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;

    // restoring divider step on the magnitude
    assign trial    = {r_rem, r_quo[SW-1]};
    assign fill_ext = {1'b0, r_fill};
    assign ge       = (trial >= fill_ext);
    assign diff     = trial - fill_ext;

    assign quo_signed = r_neg ? (~r_quo + SW'(1)) : r_quo;

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_win      = r_win;
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_rd_idx   = r_rd_idx;
        n_first    = r_first;
        n_div_cnt  = r_div_cnt;
        n_out_vld  = r_out_vld;
        n_min      = r_min;
        n_max      = r_max;
        n_sum      = r_sum;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_neg      = r_neg;
        n_out_cnt  = r_out_cnt;
        n_out_min  = r_out_min;
        n_out_max  = r_out_max;
        n_out_mean = r_out_mean;

        // result beat taken
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (full) begin
                        n_ptr  = (ptr_inc >= r_win) ? '0 : ptr_inc;
                        n_fill = r_win;
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                    n_rd_idx = '0;
                    n_first  = 1'b1;
                    n_sum    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                // fold in one read word per cycle
                if (r_rd_vld) begin
                    n_first = 1'b0;
                    n_min   = (r_first || r_rdata < r_min) ? r_rdata : r_min;
                    n_max   = (r_first || r_rdata > r_max) ? r_rdata : r_max;
                    n_sum   = r_sum + rdata_ext;
                end
                if (!rd_en && !r_rd_vld) begin
                    n_quo     = sum_mag;
                    n_rem     = '0;
                    n_neg     = r_sum[SW-1];
                    n_div_cnt = DCW'(SW);
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_rem     = ge ? diff[CW-1:0] : trial[CW-1:0];
                n_quo     = {r_quo[SW-2:0], ge};
                n_div_cnt = r_div_cnt - DCW'(1);
                if (r_div_cnt == DCW'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_cnt  = CNT_W'(r_fill);
                    n_out_min  = r_min;
                    n_out_max  = r_max;
                    n_out_mean = quo_signed[SAMPLE_BITS-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // window length write clears the window
        if (i_cfg_wr_en) begin
            n_win  = win_cfg;
            n_fill = '0;
            n_ptr  = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win     <= CW'(WIN_RST);
            r_fill    <= '0;
            r_ptr     <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_first   <= 1'b0;
            r_div_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_ptr     <= n_ptr;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= rd_en;
            r_first   <= n_first;
            r_div_cnt <= n_div_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_min      <= n_min;
        r_max      <= n_max;
        r_sum      <= n_sum;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_out_cnt  <= n_out_cnt;
        r_out_min  <= n_out_min;
        r_out_max  <= n_out_max;
        r_out_mean <= n_out_mean;
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_store[wr_addr] <= i_sample;
        end
        if (rd_en) begin
            r_rdata <= mem_store[rd_addr];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_held_count  = r_out_cnt;
    assign o_window_min  = r_out_min;
    assign o_window_max  = r_out_max;
    assign o_window_mean = r_out_mean;

    // window bookkeeping stays inside the configured length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win)
        else $error("fill count exceeds window length");

    // a scan never reads past the held entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_idx < r_fill))
        else $error("scan read beyond held entries");

    // divider remainder stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_fill))
        else $error("divider remainder out of range");

    // an accepted sample starts a scan of a non-empty window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cfg_wr_en) |=> (r_state == S_SCAN && r_fill != '0))
        else $error("accepted beat did not start a scan");

    // a pending result always reports at least one held sample
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_cnt != '0))
        else $error("result with empty window");

endmodule : sliding_window_min_max_mean_core
